// ===== sv/amstep_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package amstep_pkg;
  localparam int MemWords = 128;

  localparam logic [1:0] CMD_EXEC  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [24:0] OP_READ  = 25'd10;
  localparam logic [24:0] OP_WRITE = 25'd11;
  localparam logic [24:0] OP_LOAD  = 25'd20;
  localparam logic [24:0] OP_STORE = 25'd21;
  localparam logic [24:0] OP_ADD   = 25'd30;
  localparam logic [24:0] OP_SUB   = 25'd31;
  localparam logic [24:0] OP_DIV   = 25'd32;
  localparam logic [24:0] OP_MUL   = 25'd33;
  localparam logic [24:0] OP_JUMP  = 25'd40;
  localparam logic [24:0] OP_JNEG  = 25'd41;
  localparam logic [24:0] OP_JZ    = 25'd42;
  localparam logic [24:0] OP_HALT  = 25'd43;
  localparam logic [24:0] OP_NOT   = 25'd51;

  localparam logic signed [31:0] S32Max = 32'sh7fffffff;
  localparam logic signed [31:0] S32Min = 32'sh80000000;

  typedef struct packed {
    logic [1:0]         cmd;
    logic [6:0]         addr;
    logic signed [31:0] data;
  } in_t;

  typedef struct packed {
    logic signed [31:0] word_out;
    logic               word_out_valid;
    logic signed [31:0] acc_value;
    logic [7:0]         counter_value;
    logic               bad_address;
    logic               bad_command;
    logic               divide_by_zero;
    logic               parity_even;
    logic               halted;
  } out_t;

  function automatic logic signed [31:0] sat33(input logic signed [32:0] v);
    if (v > 33'(S32Max)) return S32Max;
    if (v < 33'(S32Min)) return S32Min;
    return v[31:0];
  endfunction
endpackage
`default_nettype wire

// ===== sv/amstep_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
module amstep_div (
  input  wire                clk,
  input  wire                rst,
  input  wire                go,
  input  wire signed [31:0]  num,
  input  wire signed [31:0]  den,
  output logic               done,
  output logic signed [31:0] quot
);
  localparam logic signed [31:0] S32MinL = amstep_pkg::S32Min;

  logic [31:0] q;
  logic [32:0] rem;
  logic [31:0] dv;
  logic [5:0]  cnt;
  logic        neg;
  logic        ovf;
  logic        running;
  logic [32:0] trial;

  assign trial = {rem[31:0], q[31]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    done <= 1'b0;
    if (rst) begin
      running <= 1'b0;
    end else if (go) begin
      running <= 1'b1;
      cnt <= 6'd0;
      rem <= '0;
      q <= num[31] ? 32'(-num) : num;
      dv <= den[31] ? 32'(-den) : den;
      neg <= num[31] ^ den[31];
      ovf <= (num == S32MinL) && (den == -32'sd1);
    end else if (running) begin
      // restoring step, one quotient bit a cycle
      if (!trial[32]) begin
        rem <= trial;
        q <= {q[30:0], 1'b1};
      end else begin
        rem <= {rem[31:0], q[31]};
        q <= {q[30:0], 1'b0};
      end
      cnt <= cnt + 6'd1;
      if (cnt == 6'd31) begin
        running <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_comb begin
    if (ovf) quot = amstep_pkg::S32Max;
    else if (neg) quot = 32'(-q);
    else quot = q;
  end
endmodule
`default_nettype wire

// ===== sv/accumulator_machine_step.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Channel | Ports                  | Transfer
// input   | start, busy, in_item   | start high and busy low
// result  | strobe, out_item       | strobe high, one cycle, no back-pressure
// Write and an out-of-range counter answer from idle; read passes S_MEMR and S_OPND;
// instructions go fetch, operand read, execute, MUL adds a product register, and
// DIVIDE waits on the iterative divider, the worst case. Busy drops with the result.
// Reset clears accumulator, counter and flags, then sweeps all 128 words of memory
// to zero with busy high. The receiver cannot stall.
module accumulator_machine_step (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   start,
  output logic                  busy,
  input  wire amstep_pkg::in_t  in_item,
  output logic                  strobe,
  output amstep_pkg::out_t      out_item
);
  localparam logic [2:0] S_CLR    = 3'd0;
  localparam logic [2:0] S_IDLE   = 3'd1;
  localparam logic [2:0] S_FETCH  = 3'd2;
  localparam logic [2:0] S_OPND   = 3'd3;
  localparam logic [2:0] S_EXEC   = 3'd4;
  localparam logic [2:0] S_DIV    = 3'd5;
  localparam logic [2:0] S_MEMR   = 3'd6;
  localparam logic [2:0] S_OPWAIT = 3'd7;

  logic [2:0]  state;
  logic [31:0] mem [amstep_pkg::MemWords];
  logic [6:0]  raddr;
  logic [31:0] rdata;
  logic        we;
  logic [6:0]  waddr;
  logic [31:0] wdata;
  logic [7:0]  clr;

  logic signed [31:0] acc;
  logic [7:0]  pc;
  logic [4:0]  flags;
  amstep_pkg::in_t item;
  logic [31:0] instr;
  logic signed [31:0] opnd;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end

  logic [24:0] opcode;
  logic [6:0]  oaddr;
  logic        op_ok;
  assign opcode = instr[31:7];
  assign oaddr = instr[6:0];
  always_comb begin
    case (opcode)
      amstep_pkg::OP_READ, amstep_pkg::OP_WRITE, amstep_pkg::OP_LOAD,
      amstep_pkg::OP_STORE, amstep_pkg::OP_ADD, amstep_pkg::OP_SUB,
      amstep_pkg::OP_DIV, amstep_pkg::OP_MUL, amstep_pkg::OP_JUMP,
      amstep_pkg::OP_JNEG, amstep_pkg::OP_JZ, amstep_pkg::OP_HALT,
      amstep_pkg::OP_NOT: op_ok = 1'b1;
      default: op_ok = 1'b0;
    endcase
  end

  logic        div_go;
  logic        div_done;
  logic signed [31:0] quot;
  amstep_div u_div (
    .clk(clk), .rst(rst), .go(div_go), .num(acc), .den(opnd),
    .done(div_done), .quot(quot)
  );

  logic signed [63:0] prod;
  logic signed [32:0] sum;
  logic signed [32:0] diff;
  assign prod = acc * opnd;
  assign sum  = 33'(acc) + 33'(opnd);
  assign diff = 33'(acc) - 33'(opnd);

  function automatic logic signed [31:0] satp(input logic signed [63:0] v);
    if (v > 64'(amstep_pkg::S32Max)) return amstep_pkg::S32Max;
    if (v < 64'(amstep_pkg::S32Min)) return amstep_pkg::S32Min;
    return v[31:0];
  endfunction

  logic signed [31:0] mulr;
  logic        mul_wait;

  assign busy = (state != S_IDLE);

  task automatic show(input logic [31:0] w, input logic v, input logic signed [31:0] a,
                      input logic [7:0] p, input logic [4:0] f);
    out_item.word_out <= w;
    out_item.word_out_valid <= v;
    out_item.acc_value <= a;
    out_item.counter_value <= p;
    out_item.bad_address <= f[0];
    out_item.bad_command <= f[1];
    out_item.divide_by_zero <= f[2];
    out_item.parity_even <= f[3];
    out_item.halted <= f[4];
  endtask

  always_ff @(posedge clk) begin
    strobe <= 1'b0;
    we <= 1'b0;
    div_go <= 1'b0;
    if (rst) begin
      state <= S_CLR;
      clr <= '0;
      acc <= '0;
      pc <= '0;
      flags <= '0;
      mul_wait <= 1'b0;
    end else begin
      case (state)
        S_CLR: begin
          we <= 1'b1;
          waddr <= clr[6:0];
          wdata <= '0;
          clr <= clr + 8'd1;
          if (clr == 8'd127) state <= S_IDLE;
        end
        S_IDLE: begin
          if (start) begin
            item <= in_item;
            case (in_item.cmd)
              amstep_pkg::CMD_EXEC: begin
                if (pc[7]) begin
                  flags <= flags | 5'b00001;
                  strobe <= 1'b1;
                  show('0, 1'b0, acc, pc, flags | 5'b00001);
                end else begin
                  raddr <= pc[6:0];
                  state <= S_FETCH;
                end
              end
              amstep_pkg::CMD_WRITE: begin
                we <= 1'b1;
                waddr <= in_item.addr;
                wdata <= in_item.data;
                strobe <= 1'b1;
                show('0, 1'b0, acc, pc, flags);
              end
              amstep_pkg::CMD_READ: begin
                raddr <= in_item.addr;
                state <= S_MEMR;
              end
              default: begin
                strobe <= 1'b1;
                show('0, 1'b0, acc, pc, flags);
              end
            endcase
          end
        end
        S_MEMR: state <= S_OPND;
        S_FETCH: state <= S_OPND;
        S_OPND: begin
          if (item.cmd == amstep_pkg::CMD_READ) begin
            strobe <= 1'b1;
            show(rdata, 1'b1, acc, pc, flags);
            state <= S_IDLE;
          end else begin
            instr <= rdata;
            raddr <= rdata[6:0];
            state <= S_OPWAIT;
            mul_wait <= 1'b0;
          end
        end
        // hold while the operand read completes
        S_OPWAIT: state <= S_DIV;
        S_DIV: begin
          // operand read lands here; latch it and start divider if needed
          opnd <= rdata;
          if (opcode == amstep_pkg::OP_DIV && op_ok && rdata != 0) div_go <= 1'b1;
          state <= S_EXEC;
        end
        S_EXEC: begin
          if (!op_ok) begin
            flags <= flags | 5'b00010;
            strobe <= 1'b1;
            show('0, 1'b0, acc, pc, flags | 5'b00010);
            state <= S_IDLE;
          end else begin
            case (opcode)
              amstep_pkg::OP_READ: begin
                we <= 1'b1; waddr <= oaddr; wdata <= item.data;
                pc <= pc + 8'd1;
                strobe <= 1'b1; show('0, 1'b0, acc, pc + 8'd1, flags);
                state <= S_IDLE;
              end
              amstep_pkg::OP_WRITE: begin
                pc <= pc + 8'd1;
                strobe <= 1'b1; show(opnd, 1'b1, acc, pc + 8'd1, flags);
                state <= S_IDLE;
              end
              amstep_pkg::OP_LOAD: begin
                acc <= opnd; pc <= pc + 8'd1;
                strobe <= 1'b1; show('0, 1'b0, opnd, pc + 8'd1, flags);
                state <= S_IDLE;
              end
              amstep_pkg::OP_STORE: begin
                we <= 1'b1; waddr <= oaddr; wdata <= acc;
                pc <= pc + 8'd1;
                strobe <= 1'b1; show('0, 1'b0, acc, pc + 8'd1, flags);
                state <= S_IDLE;
              end
              amstep_pkg::OP_ADD, amstep_pkg::OP_SUB: begin
                logic signed [31:0] r;
                logic [4:0] f;
                r = amstep_pkg::sat33(opcode == amstep_pkg::OP_ADD ? sum : diff);
                f = {flags[4], ~r[0], flags[2:0]};
                acc <= r; flags <= f; pc <= pc + 8'd1;
                strobe <= 1'b1; show('0, 1'b0, r, pc + 8'd1, f);
                state <= S_IDLE;
              end
              amstep_pkg::OP_MUL: begin
                // saturate the product and register it before writing back
                if (!mul_wait) begin
                  mulr <= satp(prod);
                  mul_wait <= 1'b1;
                end else begin
                  acc <= mulr; flags <= {flags[4], ~mulr[0], flags[2:0]};
                  pc <= pc + 8'd1;
                  strobe <= 1'b1;
                  show('0, 1'b0, mulr, pc + 8'd1, {flags[4], ~mulr[0], flags[2:0]});
                  state <= S_IDLE;
                end
              end
              amstep_pkg::OP_DIV: begin
                if (opnd == 0) begin
                  flags <= flags | 5'b00110;
                  strobe <= 1'b1; show('0, 1'b0, acc, pc, flags | 5'b00110);
                  state <= S_IDLE;
                end else if (div_done) begin
                  acc <= quot; flags <= {flags[4], ~quot[0], flags[2:0]};
                  pc <= pc + 8'd1;
                  strobe <= 1'b1;
                  show('0, 1'b0, quot, pc + 8'd1, {flags[4], ~quot[0], flags[2:0]});
                  state <= S_IDLE;
                end
              end
              amstep_pkg::OP_JUMP, amstep_pkg::OP_JNEG, amstep_pkg::OP_JZ: begin
                logic [7:0] n;
                if (opcode == amstep_pkg::OP_JUMP ||
                    (opcode == amstep_pkg::OP_JNEG && acc[31]) ||
                    (opcode == amstep_pkg::OP_JZ && acc == 0)) n = {1'b0, oaddr};
                else n = pc + 8'd1;
                pc <= n;
                strobe <= 1'b1; show('0, 1'b0, acc, n, flags);
                state <= S_IDLE;
              end
              amstep_pkg::OP_HALT: begin
                flags <= flags | 5'b10000; pc <= pc + 8'd1;
                strobe <= 1'b1; show('0, 1'b0, acc, pc + 8'd1, flags | 5'b10000);
                state <= S_IDLE;
              end
              default: begin
                we <= 1'b1; waddr <= item.addr; wdata <= ~acc;
                pc <= pc + 8'd1;
                strobe <= 1'b1; show('0, 1'b0, acc, pc + 8'd1, flags);
                state <= S_IDLE;
              end
            endcase
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire
